### hdl/timer_queue_manager_unit_assert.svh
// ----------------------------------------------------------------------------
// Timer queue manager: assertion macros
// Shared macro forms for the concurrent checks on the block ports.
// ----------------------------------------------------------------------------
`ifndef TIMER_QUEUE_MANAGER_UNIT_ASSERT_SVH
`define TIMER_QUEUE_MANAGER_UNIT_ASSERT_SVH

// same-cycle implication
`define TQM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer queue manager check failed");

// next-cycle implication
`define TQM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer queue manager check failed");

`endif

### hdl/tqm_pkg.sv
// ----------------------------------------------------------------------------
// Timer queue manager package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tqm_pkg;

   localparam int unsigned NUM_TIMERS_DEF = 16;
   localparam int unsigned TIME_BITS_DEF  = 48;
   localparam int unsigned MAX_RESULTS    = 16;
   localparam int unsigned ECNT_W         = $clog2(MAX_RESULTS + 1);
   localparam int unsigned EPTR_W         = $clog2(MAX_RESULTS);

   localparam int unsigned CMD_W    = 3;
   localparam int unsigned ID_W     = 4;
   localparam int unsigned PERIOD_W = 32;
   localparam int unsigned STS_W    = 2;
   localparam int unsigned FTIME_W  = 48;

   localparam logic [FTIME_W-1:0] ROLLOVER_RESET = 48'd3600000;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD     = 3'd0,
      CMD_CANCEL  = 3'd1,
      CMD_REFRESH = 3'd2,
      CMD_RESET   = 3'd3,
      CMD_NEXT    = 3'd4,
      CMD_COLLECT = 3'd5
   } tqm_cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK       = 2'd0,
      STS_INACTIVE = 2'd1,
      STS_BUSY     = 2'd2
   } tqm_status_type;

   typedef enum logic [1:0] {
      SCAN_FRONT,
      SCAN_DUE,
      SCAN_PICK
   } tqm_scan_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_OP,
      ST_WRITE,
      ST_FRONT,
      ST_FRONT_END,
      ST_DUE,
      ST_PICK,
      ST_PICKED,
      ST_RESULT
   } tqm_state_type;

   typedef struct packed {
      logic         ready;
      logic         load;
      logic         op;
      logic         write;
      logic         scan;
      tqm_scan_type mode;
      logic         front_end;
      logic         picked;
      logic         out_load;
   } tqm_ctrl_type;

   typedef struct packed {
      tqm_cmd_type cmd;
      logic        arm;
      logic        scan_last;
      logic        pick_more;
      logic        out_free;
      logic        out_last;
   } tqm_stat_type;

endpackage

### hdl/timer_queue_manager_unit.sv
// Steps per item: slot read, decode, then straight to the result for cancel, failed commands
// and unknown codes; refresh writes the slot first; next query scans for the front; an armed
// add or reset writes the slot, then scans for the front. Collect scans for due slots, then
// runs pick passes for up to 16 of them, then one result item per cycle unless stalled.
// Throughput: one item in work at a time, the next taken the cycle after its final result loads.
// Reset (sync, active high) clears slots, notice, previous time; window 3600000; tables kept.
// ----------------------------------------------------------------------------
// Timer queue manager unit
// Slot table of software timers with add/cancel/refresh/reset, next-deadline
// query and collection of expired timers in deadline order.
// ----------------------------------------------------------------------------
module timer_queue_manager_unit #(
   parameter int unsigned NUM_TIMERS = tqm_pkg::NUM_TIMERS_DEF,
   parameter int unsigned TIME_BITS  = tqm_pkg::TIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tqm_pkg::CMD_W-1:0]    req_command,
   input  logic [tqm_pkg::ID_W-1:0]     req_timer_id,
   input  logic [tqm_pkg::PERIOD_W-1:0] req_period_ms,
   input  logic                         req_recurring,
   input  logic                         req_restart,
   input  logic [tqm_pkg::FTIME_W-1:0]  req_now_ms,
   // rollover window register
   input  logic                         csr_wr_en,
   input  logic [tqm_pkg::FTIME_W-1:0]  csr_wr_data,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tqm_pkg::STS_W-1:0]    rsp_status,
   output logic                         rsp_front_flag,
   output logic [tqm_pkg::FTIME_W-1:0]  rsp_remaining_ms,
   output logic [tqm_pkg::ID_W-1:0]     rsp_expired_id,
   output logic                         rsp_expired_valid,
   output logic                         rsp_last,
   output logic                         rsp_has_timer
);
   import tqm_pkg::*;

   tqm_ctrl_type ctrl;
   tqm_stat_type stat;

   // stall the request side whenever an item is in work; the result register
   // holds the last item while the next one is accepted
   assign req_stall = !ctrl.ready;

   tqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   tqm_datapath #(
      .NUM_TIMERS (NUM_TIMERS),
      .TIME_BITS  (TIME_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .req_command       (req_command),
      .req_timer_id      (req_timer_id),
      .req_period_ms     (req_period_ms),
      .req_recurring     (req_recurring),
      .req_restart       (req_restart),
      .req_now_ms        (req_now_ms),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_front_flag    (rsp_front_flag),
      .rsp_remaining_ms  (rsp_remaining_ms),
      .rsp_expired_id    (rsp_expired_id),
      .rsp_expired_valid (rsp_expired_valid),
      .rsp_last          (rsp_last),
      .rsp_has_timer     (rsp_has_timer)
   );

endmodule

### hdl/tqm_ctrl.sv
// ----------------------------------------------------------------------------
// Timer queue manager controller
// Sequences slot access, table scans, collection and result delivery.
// ----------------------------------------------------------------------------
module tqm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  tqm_pkg::tqm_stat_type stat,
   output tqm_pkg::tqm_ctrl_type ctrl
);
   import tqm_pkg::*;

   tqm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_OP;
         end
         ST_OP: begin
            priority if (stat.arm)               state_in = ST_WRITE;
            else if (stat.cmd == CMD_NEXT)       state_in = ST_FRONT;
            else if (stat.cmd == CMD_COLLECT)    state_in = ST_DUE;
            else                                 state_in = ST_RESULT;
         end
         ST_WRITE: begin
            state_in = (stat.cmd == CMD_REFRESH) ? ST_RESULT : ST_FRONT;
         end
         ST_FRONT: begin
            if (stat.scan_last) state_in = ST_FRONT_END;
         end
         ST_FRONT_END: begin
            state_in = ST_RESULT;
         end
         ST_DUE: begin
            if (stat.scan_last) state_in = ST_PICK;
         end
         ST_PICK: begin
            if (stat.scan_last) state_in = ST_PICKED;
         end
         ST_PICKED: begin
            state_in = stat.pick_more ? ST_PICK : ST_RESULT;
         end
         ST_RESULT: begin
            if (stat.out_free && stat.out_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl           = '0;
      ctrl.mode      = SCAN_FRONT;
      ctrl.ready     = (state_ff == ST_IDLE);
      ctrl.load      = (state_ff == ST_IDLE) && req_valid;
      ctrl.op        = (state_ff == ST_OP);
      ctrl.write     = (state_ff == ST_WRITE);
      ctrl.scan      = (state_ff == ST_FRONT) || (state_ff == ST_DUE) ||
                       (state_ff == ST_PICK);
      if (state_ff == ST_DUE)  ctrl.mode = SCAN_DUE;
      if (state_ff == ST_PICK) ctrl.mode = SCAN_PICK;
      ctrl.front_end = (state_ff == ST_FRONT_END);
      ctrl.picked    = (state_ff == ST_PICKED);
      ctrl.out_load  = (state_ff == ST_RESULT) && stat.out_free;
   end

endmodule

### hdl/tqm_datapath.sv
// ----------------------------------------------------------------------------
// Timer queue manager datapath
// Slot tables, scan compare unit, emission queue and result register.
// ----------------------------------------------------------------------------
module tqm_datapath #(
   parameter int unsigned NUM_TIMERS = tqm_pkg::NUM_TIMERS_DEF,
   parameter int unsigned TIME_BITS  = tqm_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tqm_pkg::tqm_ctrl_type          ctrl,
   output tqm_pkg::tqm_stat_type          stat,
   input  logic [tqm_pkg::CMD_W-1:0]      req_command,
   input  logic [tqm_pkg::ID_W-1:0]       req_timer_id,
   input  logic [tqm_pkg::PERIOD_W-1:0]   req_period_ms,
   input  logic                           req_recurring,
   input  logic                           req_restart,
   input  logic [tqm_pkg::FTIME_W-1:0]    req_now_ms,
   input  logic                           csr_wr_en,
   input  logic [tqm_pkg::FTIME_W-1:0]    csr_wr_data,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [tqm_pkg::STS_W-1:0]      rsp_status,
   output logic                           rsp_front_flag,
   output logic [tqm_pkg::FTIME_W-1:0]    rsp_remaining_ms,
   output logic [tqm_pkg::ID_W-1:0]       rsp_expired_id,
   output logic                           rsp_expired_valid,
   output logic                           rsp_last,
   output logic                           rsp_has_timer
);
   import tqm_pkg::*;

   localparam int unsigned IDX_W = $clog2(NUM_TIMERS);
   localparam int unsigned CNT_W = $clog2(NUM_TIMERS + 1);

   typedef logic [TIME_BITS-1:0] time_type;

   function automatic time_type sat_add(input time_type a, input time_type b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
   endfunction

   // item registers
   tqm_cmd_type          cmd_ff;
   logic [ID_W-1:0]      id_ff;
   logic [PERIOD_W-1:0]  per_ff;
   logic                 rec_ff;
   logic                 fnow_ff;
   time_type             now_ff;

   // slot tables
   logic [NUM_TIMERS-1:0] active_ff, active_in;
   logic [NUM_TIMERS-1:0] recur_ff, recur_in;
   logic [NUM_TIMERS-1:0] due_ff, due_in;
   logic [NUM_TIMERS-1:0] done_ff, done_in;
   time_type              deadline_mem_ff [NUM_TIMERS];
   logic [PERIOD_W-1:0]   period_mem_ff [NUM_TIMERS];
   time_type              rd_dl_ff;
   logic [PERIOD_W-1:0]   rd_per_ff;

   // global state
   time_type prev_ff, prev_in;
   time_type win_ff, win_in;
   logic     pending_ff, pending_in;

   // op results
   tqm_status_type      status_ff;
   logic                front_flag_ff;
   logic [FTIME_W-1:0]  remain_ff;
   time_type            start_ff;
   logic [PERIOD_W-1:0] wper_ff;
   logic                roll_ff;

   // scan unit
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             best_valid_ff;
   logic [IDX_W-1:0] best_idx_ff;
   time_type         best_dl_ff;
   logic [PERIOD_W-1:0] best_per_ff;

   // emission queue
   logic [IDX_W-1:0]  emit_q_ff [MAX_RESULTS];
   logic [ECNT_W-1:0] emit_cnt_ff;
   logic [ECNT_W-1:0] out_ptr_ff;

   logic rsp_valid_ff, rsp_valid_in;

   // combinational
   logic             valid_id;
   logic [IDX_W-1:0] id_idx;
   logic             slot_act;
   logic             arm;
   tqm_status_type   op_sts;
   time_type         op_start;
   logic [PERIOD_W-1:0] op_wper;
   time_type         rd_per_ext;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   time_type         wr_dl;
   logic             dl_we;
   logic             eval;
   logic [IDX_W-1:0] ent;
   logic             cand;
   logic             scan_last;
   logic             emitted;
   logic             out_last;
   logic             commit;

   assign valid_id   = (32'(id_ff) < NUM_TIMERS);
   assign id_idx     = IDX_W'(id_ff);
   assign slot_act   = valid_id && active_ff[id_idx];
   assign rd_per_ext = TIME_BITS'(rd_per_ff);

   // decode of the addressed slot, with its table entry registered in the read state
   always_comb begin
      arm      = 1'b0;
      op_sts   = STS_OK;
      op_start = now_ff;
      op_wper  = per_ff;
      unique case (cmd_ff)
         CMD_ADD: begin
            if (!valid_id)     op_sts = STS_INACTIVE;
            else if (slot_act) op_sts = STS_BUSY;
            else               arm = 1'b1;
         end
         CMD_CANCEL: begin
            if (!slot_act) op_sts = STS_INACTIVE;
         end
         CMD_REFRESH: begin
            op_wper = rd_per_ff;
            if (!slot_act) op_sts = STS_INACTIVE;
            else           arm = 1'b1;
         end
         CMD_RESET: begin
            priority if (valid_id && (per_ff == rd_per_ff) && !fnow_ff) begin
               op_sts = STS_OK;
            end else if (!slot_act) begin
               op_sts = STS_INACTIVE;
            end else begin
               arm = 1'b1;
               if (!fnow_ff) begin
                  op_start = (rd_dl_ff >= rd_per_ext) ? (rd_dl_ff - rd_per_ext) : '0;
               end
            end
         end
         default: begin
            op_sts = STS_OK;
         end
      endcase
   end

   // scan bookkeeping
   assign scan_last = ctrl.scan && (cnt_ff == CNT_W'(NUM_TIMERS));
   assign cnt_in    = (ctrl.scan && !scan_last) ? cnt_ff + 1'b1 : '0;
   assign rd_addr   = ctrl.scan ? IDX_W'(cnt_ff) : id_idx;
   assign eval      = ctrl.scan && (cnt_ff != '0);
   assign ent       = IDX_W'(cnt_ff - 1'b1);
   assign cand      = (ctrl.mode == SCAN_PICK) ? (due_ff[ent] && !done_ff[ent])
                                               : active_ff[ent];

   assign commit  = ctrl.picked && best_valid_ff;
   assign wr_addr = ctrl.picked ? best_idx_ff : id_idx;
   assign wr_dl   = ctrl.picked ? sat_add(now_ff, TIME_BITS'(best_per_ff))
                                : sat_add(start_ff, TIME_BITS'(wper_ff));
   assign dl_we   = ctrl.write || (commit && recur_ff[best_idx_ff]);

   assign emitted  = (emit_cnt_ff != '0);
   assign out_last = !emitted || (out_ptr_ff == emit_cnt_ff - 1'b1);

   // table memories
   always_ff @(posedge clock) begin
      if (dl_we)      deadline_mem_ff[wr_addr] <= wr_dl;
      if (ctrl.write) period_mem_ff[wr_addr]   <= wper_ff;
      rd_dl_ff  <= deadline_mem_ff[rd_addr];
      rd_per_ff <= period_mem_ff[rd_addr];
   end

   // control state next values
   always_comb begin
      active_in  = active_ff;
      recur_in   = recur_ff;
      due_in     = due_ff;
      done_in    = done_ff;
      prev_in    = prev_ff;
      pending_in = pending_ff;
      win_in     = win_ff;
      if (csr_wr_en) win_in = TIME_BITS'(csr_wr_data);
      if (ctrl.load) done_in = '0;
      if (ctrl.op) begin
         if (cmd_ff == CMD_CANCEL && slot_act) active_in[id_idx] = 1'b0;
         if (cmd_ff == CMD_NEXT)    pending_in = 1'b0;
         if (cmd_ff == CMD_COLLECT) prev_in = now_ff;
      end
      if (ctrl.write) begin
         active_in[id_idx] = 1'b1;
         if (cmd_ff == CMD_ADD) recur_in[id_idx] = rec_ff;
      end
      if (eval && ctrl.mode == SCAN_DUE) begin
         due_in[ent] = active_ff[ent] && (roll_ff || (rd_dl_ff <= now_ff));
      end
      if (ctrl.front_end && cmd_ff != CMD_NEXT && best_valid_ff &&
          best_idx_ff == id_idx && !pending_ff) begin
         pending_in = 1'b1;
      end
      if (commit) begin
         done_in[best_idx_ff] = 1'b1;
         if (!recur_ff[best_idx_ff]) active_in[best_idx_ff] = 1'b0;
      end
   end

   assign rsp_valid_in = ctrl.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         recur_ff     <= '0;
         prev_ff      <= '0;
         pending_ff   <= 1'b0;
         win_ff       <= TIME_BITS'(ROLLOVER_RESET);
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         emit_cnt_ff  <= '0;
         out_ptr_ff   <= '0;
      end else begin
         active_ff    <= active_in;
         recur_ff     <= recur_in;
         prev_ff      <= prev_in;
         pending_ff   <= pending_in;
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (ctrl.load) begin
            emit_cnt_ff <= '0;
            out_ptr_ff  <= '0;
         end else begin
            if (commit)        emit_cnt_ff <= emit_cnt_ff + 1'b1;
            if (ctrl.out_load) out_ptr_ff  <= out_ptr_ff + 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      due_ff  <= due_in;
      done_ff <= done_in;
      if (ctrl.load) begin
         cmd_ff        <= tqm_cmd_type'(req_command);
         id_ff         <= req_timer_id;
         per_ff        <= req_period_ms;
         rec_ff        <= req_recurring;
         fnow_ff       <= req_restart;
         now_ff        <= TIME_BITS'(req_now_ms);
         front_flag_ff <= 1'b0;
         remain_ff     <= '0;
      end
      if (ctrl.op) begin
         status_ff <= op_sts;
         start_ff  <= op_start;
         wper_ff   <= op_wper;
         roll_ff   <= (prev_ff > win_ff) && (now_ff < prev_ff - win_ff);
      end
      if (ctrl.scan && cnt_ff == '0) begin
         best_valid_ff <= 1'b0;
      end else if (eval && ctrl.mode != SCAN_DUE && cand &&
                   (!best_valid_ff || rd_dl_ff < best_dl_ff)) begin
         best_valid_ff <= 1'b1;
         best_idx_ff   <= ent;
         best_dl_ff    <= rd_dl_ff;
         best_per_ff   <= rd_per_ff;
      end
      if (ctrl.front_end) begin
         if (cmd_ff == CMD_NEXT) begin
            if (!best_valid_ff)          remain_ff <= '1;
            else if (now_ff >= best_dl_ff) remain_ff <= '0;
            else                         remain_ff <= FTIME_W'(best_dl_ff - now_ff);
         end else begin
            front_flag_ff <= best_valid_ff && (best_idx_ff == id_idx) && !pending_ff;
         end
      end
      if (commit) emit_q_ff[EPTR_W'(emit_cnt_ff)] <= best_idx_ff;
      if (ctrl.out_load) begin
         rsp_status        <= status_ff;
         rsp_front_flag    <= front_flag_ff;
         rsp_remaining_ms  <= remain_ff;
         rsp_expired_id    <= emitted ? ID_W'(emit_q_ff[EPTR_W'(out_ptr_ff)]) : '0;
         rsp_expired_valid <= emitted;
         rsp_last          <= out_last;
         rsp_has_timer     <= |active_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      stat.cmd       = cmd_ff;
      stat.arm       = arm;
      stat.scan_last = scan_last;
      stat.pick_more = best_valid_ff && (emit_cnt_ff != ECNT_W'(MAX_RESULTS - 1));
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
      stat.out_last  = out_last;
   end

endmodule

### hdl/tqm_checker.sv
// ----------------------------------------------------------------------------
// Timer queue manager checker
// Port-level checks on the result channel and request acceptance.
// ----------------------------------------------------------------------------
`include "timer_queue_manager_unit_assert.svh"

module tqm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [tqm_pkg::STS_W-1:0]    rsp_status,
   input logic                         rsp_front_flag,
   input logic [tqm_pkg::FTIME_W-1:0]  rsp_remaining_ms,
   input logic [tqm_pkg::ID_W-1:0]     rsp_expired_id,
   input logic                         rsp_expired_valid,
   input logic                         rsp_last,
   input logic                         rsp_has_timer
);
   import tqm_pkg::*;

   // hold a stalled result
   `TQM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_expired_id) && $stable(rsp_last))

   // an accepted item occupies the block for at least the next cycle
   `TQM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // expired ids only come with clean status fields
   `TQM_ASSERT_NOW(a_expired_clean, clock, reset, rsp_valid && rsp_expired_valid,
      rsp_status == STS_OK && !rsp_front_flag && rsp_remaining_ms == '0)

   // a raised front notice implies a live timer
   `TQM_ASSERT_NOW(a_front_live, clock, reset, rsp_valid && rsp_front_flag,
      rsp_has_timer && rsp_status == STS_OK)

endmodule

bind timer_queue_manager_unit tqm_checker u_tqm_checker (.*);

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue manager testbench
// Drives random and directed timer commands, predicts every result item from
// a local model of the slot table and checks each one field by field.
// ----------------------------------------------------------------------------
module testbench;
   import tqm_pkg::*;

   localparam int          SLOTS      = 16;
   localparam int          NO_SLOT    = SLOTS;
   localparam logic [47:0] TIME_MAX   = 48'hFFFF_FFFF_FFFF;
   localparam logic [2:0]  CMD_SPARE6 = 3'd6;
   localparam logic [2:0]  CMD_SPARE7 = 3'd7;
   localparam int          CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [2:0]  cmd;
      logic [3:0]  id;
      logic [31:0] period;
      logic        recurring;
      logic        restart;
      logic [47:0] now;
   } timer_req_type;

   typedef struct {
      logic [1:0]  status;
      logic        front_flag;
      logic [47:0] remaining;
      logic [3:0]  exp_id;
      logic        exp_valid;
      logic        last;
      logic        has_timer;
   } timer_rsp_type;

   // Scoreboard: holds the slot table image and the queue of pending results.
   class scoreboard_type;
      bit            active [SLOTS];
      bit            rec    [SLOTS];
      logic [31:0]   period [SLOTS];
      logic [47:0]   due_at [SLOTS];
      logic [47:0]   last_collect;
      bit            notice;
      logic [47:0]   window;
      timer_rsp_type pending [$];
      int            mismatches;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            active[i] = 0; rec[i] = 0; period[i] = '0; due_at[i] = '0;
         end
         last_collect = '0;
         notice       = 0;
         window       = ROLLOVER_RESET;
         mismatches   = 0;
      endfunction

      function logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
         logic [48:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[48] ? TIME_MAX : s[47:0];
      endfunction

      function bit earlier(int a, int b);
         if (due_at[a] != due_at[b]) return due_at[a] < due_at[b];
         return a < b;
      endfunction

      function int earliest();
         int best;
         best = NO_SLOT;
         for (int i = 0; i < SLOTS; i++)
            if (active[i] && (best == NO_SLOT || earlier(i, best))) best = i;
         return best;
      endfunction

      function bit raise_notice(int id);
         if (earliest() == id && !notice) begin
            notice = 1;
            return 1;
         end
         return 0;
      endfunction

      // Advance the table for one accepted item and queue its result items.
      function void note_request(timer_req_type r);
         timer_rsp_type o;
         int            id;
         int            hits [$];
         bit            due [SLOTS];
         bit            roll;
         int            f, best;
         logic [47:0]   start;
         id = r.id;
         o  = '{status: STS_OK, front_flag: 0, remaining: '0, exp_id: '0,
                exp_valid: 0, last: 1, has_timer: 0};
         case (r.cmd)
            CMD_ADD: begin
               if (active[id]) o.status = STS_BUSY;
               else begin
                  active[id] = 1;
                  rec[id]    = r.recurring;
                  period[id] = r.period;
                  due_at[id] = sat_sum(r.now, {16'd0, r.period});
                  o.front_flag = raise_notice(id);
               end
            end
            CMD_CANCEL: begin
               if (!active[id]) o.status = STS_INACTIVE;
               else active[id] = 0;
            end
            CMD_REFRESH: begin
               if (!active[id]) o.status = STS_INACTIVE;
               else due_at[id] = sat_sum(r.now, {16'd0, period[id]});
            end
            CMD_RESET: begin
               // same period without restart leaves the slot alone
               if (!(r.period == period[id] && !r.restart)) begin
                  if (!active[id]) o.status = STS_INACTIVE;
                  else begin
                     if (r.restart) start = r.now;
                     else start = (due_at[id] >= {16'd0, period[id]}) ?
                                  due_at[id] - {16'd0, period[id]} : '0;
                     period[id] = r.period;
                     due_at[id] = sat_sum(start, {16'd0, r.period});
                     o.front_flag = raise_notice(id);
                  end
               end
            end
            CMD_NEXT: begin
               notice = 0;
               f = earliest();
               if (f == NO_SLOT)           o.remaining = TIME_MAX;
               else if (r.now >= due_at[f]) o.remaining = '0;
               else                         o.remaining = due_at[f] - r.now;
            end
            CMD_COLLECT: begin
               roll = last_collect > window && r.now < last_collect - window;
               last_collect = r.now;
               for (int i = 0; i < SLOTS; i++)
                  due[i] = active[i] && (roll || due_at[i] <= r.now);
               while (hits.size() < MAX_RESULTS) begin
                  best = NO_SLOT;
                  for (int i = 0; i < SLOTS; i++)
                     if (due[i] && (best == NO_SLOT || earlier(i, best))) best = i;
                  if (best == NO_SLOT) break;
                  due[best] = 0;
                  hits = {hits, best};
               end
               foreach (hits[k]) begin
                  if (rec[hits[k]]) due_at[hits[k]] = sat_sum(r.now, {16'd0, period[hits[k]]});
                  else active[hits[k]] = 0;
               end
            end
            default: ;
         endcase
         o.has_timer = earliest() != NO_SLOT;
         if (hits.size() == 0) pending = {pending, o};
         else foreach (hits[k]) begin
            o.exp_id    = 4'(hits[k]);
            o.exp_valid = 1;
            o.last      = (k == hits.size() - 1);
            pending = {pending, o};
         end
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task check_result(timer_rsp_type got);
         timer_rsp_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result item id=%0d", got.exp_id));
            return;
         end
         e = pending.pop_front();
         if (got.status    !== e.status)
            report($sformatf("status %0d, expected %0d", got.status, e.status));
         if (got.front_flag !== e.front_flag)
            report($sformatf("front flag %0b, expected %0b", got.front_flag, e.front_flag));
         if (got.remaining !== e.remaining)
            report($sformatf("remaining %0h, expected %0h", got.remaining, e.remaining));
         if (got.exp_id    !== e.exp_id)
            report($sformatf("expired_id %0d, expected %0d", got.exp_id, e.exp_id));
         if (got.exp_valid !== e.exp_valid)
            report($sformatf("expired_valid %0b, expected %0b", got.exp_valid, e.exp_valid));
         if (got.last      !== e.last)
            report($sformatf("last %0b, expected %0b", got.last, e.last));
         if (got.has_timer !== e.has_timer)
            report($sformatf("has_timer %0b, expected %0b", got.has_timer, e.has_timer));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_command = '0;
   logic [3:0]  req_timer_id = '0;
   logic [31:0] req_period_ms = '0;
   logic        req_recurring = 0;
   logic        req_restart = 0;
   logic [47:0] req_now_ms = '0;
   logic        csr_wr_en = 0;
   logic [47:0] csr_wr_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic        rsp_front_flag;
   logic [47:0] rsp_remaining_ms;
   logic [3:0]  rsp_expired_id;
   logic        rsp_expired_valid;
   logic        rsp_last;
   logic        rsp_has_timer;

   scoreboard_type sb = new();
   int          cycles = 0;
   bit          calm = 0;      // stretch with no idling on either side
   bit          written [SLOTS];
   logic [47:0] clock_ms = 48'd1000;

   timer_queue_manager_unit dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_command, .req_timer_id, .req_period_ms,
      .req_recurring, .req_restart, .req_now_ms,
      .csr_wr_en, .csr_wr_data,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_front_flag, .rsp_remaining_ms,
      .rsp_expired_id, .rsp_expired_valid, .rsp_last, .rsp_has_timer
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stall the result side at random, except during the calm stretch.
   always @(negedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);
   end

   // Sample accepted result items at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{status: rsp_status, front_flag: rsp_front_flag,
                           remaining: rsp_remaining_ms, exp_id: rsp_expired_id,
                           exp_valid: rsp_expired_valid, last: rsp_last,
                           has_timer: rsp_has_timer});
   end

   // Present one item from a falling edge; return at the falling edge after acceptance.
   task automatic send(timer_req_type r);
      // idle gaps first, so they fall on every phase of the block's work
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_command   <= r.cmd;
      req_timer_id  <= r.id;
      req_period_ms <= r.period;
      req_recurring <= r.recurring;
      req_restart   <= r.restart;
      req_now_ms    <= r.now;
      req_valid     <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      if (r.cmd == CMD_ADD) written[r.id] = 1;
      @(negedge clock);
   endtask

   task automatic issue(logic [2:0] cmd, int id, logic [31:0] per, bit rc, bit fn,
                        logic [47:0] now);
      timer_req_type r;
      r = '{cmd: cmd, id: id[3:0], period: per, recurring: rc, restart: fn, now: now};
      send(r);
   endtask

   // Drain every pending result, then hold off before touching the register.
   task automatic settle();
      req_valid <= 0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_window(logic [47:0] w);
      csr_wr_en   <= 1;
      csr_wr_data <= w;
      @(negedge clock);
      csr_wr_en   <= 0;
      sb.window = w;
   endtask

   function automatic logic [31:0] pick_period();
      int p;
      p = $urandom_range(99);
      if (p < 10) return '0;
      if (p < 20) return $urandom;
      return $urandom_range(400);
   endfunction

   // One random item; mostly well-formed traffic around an advancing clock.
   task automatic random_item();
      int          p, id;
      logic [2:0]  cmd;
      p = $urandom_range(99);
      // move the time base: mostly forward, sometimes a random jump, a jump back or to the top
      if (p < 3)      clock_ms = 48'({$urandom, $urandom});
      else if (p < 5) clock_ms = TIME_MAX - $urandom_range(500);
      else if (p < 8) clock_ms = clock_ms - {16'd0, $urandom};
      else            clock_ms = clock_ms + $urandom_range(150);
      id = $urandom_range(SLOTS - 1);
      p  = $urandom_range(99);
      if      (p < 30) cmd = CMD_ADD;
      else if (p < 40) cmd = CMD_CANCEL;
      else if (p < 50) cmd = CMD_REFRESH;
      else if (p < 65) cmd = CMD_RESET;
      else if (p < 78) cmd = CMD_NEXT;
      else if (p < 96) cmd = CMD_COLLECT;
      else             cmd = p[0] ? CMD_SPARE6 : CMD_SPARE7;
      // never reset a slot whose period was never written
      if (cmd == CMD_RESET && !written[id]) cmd = CMD_ADD;
      if (cmd == CMD_RESET && $urandom_range(3) == 0)
         issue(cmd, id, sb.period[id], 0, 0, clock_ms);
      else
         issue(cmd, id, pick_period(), 1'($urandom_range(1)), 1'($urandom_range(1)),
               clock_ms);
   endtask

   // Arm every free slot with a short period, then collect them all at once.
   task automatic burst();
      for (int i = 0; i < SLOTS; i++)
         issue(CMD_ADD, i, $urandom_range(3), 1'($urandom_range(1)), 0, clock_ms);
      clock_ms = clock_ms + 10;
      issue(CMD_COLLECT, 0, '0, 0, 0, clock_ms);
   endtask

   initial begin
      logic [47:0] windows [4];
      windows = '{ROLLOVER_RESET, 48'd0, TIME_MAX, 48'd5000};
      for (int i = 0; i < SLOTS; i++) written[i] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed part: corners of each command.
      issue(CMD_ADD, 0, 100, 1, 0, 48'd1000);             // first timer becomes front
      issue(CMD_ADD, 0, 5, 0, 0, 48'd1000);               // slot already active
      issue(CMD_ADD, 15, 32'hFFFF_FFFF, 0, 1, 48'd1000);  // widest period
      issue(CMD_NEXT, 0, '0, 0, 0, 48'd1000);             // clears the notice
      issue(CMD_ADD, 3, 50, 0, 0, 48'd1000);              // new front after notice cleared
      issue(CMD_CANCEL, 7, '0, 0, 0, 48'd1000);           // inactive slot
      issue(CMD_CANCEL, 15, '0, 0, 0, 48'd1000);
      issue(CMD_REFRESH, 3, '0, 0, 0, 48'd1010);
      issue(CMD_REFRESH, 9, '0, 0, 0, 48'd1010);          // inactive slot
      issue(CMD_RESET, 0, 100, 0, 0, 48'd1020);           // same period, keep start
      issue(CMD_RESET, 0, 20, 0, 0, 48'd1020);            // re-period from old start
      issue(CMD_RESET, 3, 10, 0, 1, 48'd1020);            // restart from now
      issue(CMD_RESET, 15, 7, 0, 1, 48'd1020);            // cancelled slot
      issue(CMD_COLLECT, 0, '0, 0, 0, 48'd5000);          // several due in order
      issue(CMD_ADD, 5, 32'hFFFF_FFFF, 1, 0, TIME_MAX - 4); // saturating deadline
      issue(CMD_NEXT, 0, '0, 0, 0, TIME_MAX - 4);
      issue(CMD_COLLECT, 0, '0, 0, 0, TIME_MAX - 1);      // only the recurring slot 0 is due
      issue(CMD_COLLECT, 0, '0, 0, 0, 48'd0);             // backward jump: rollover
      issue(CMD_SPARE6, 2, 32'hFFFF_FFFF, 1, 1, TIME_MAX);
      issue(CMD_SPARE7, 4, '0, 0, 0, 48'd0);
      issue(CMD_CANCEL, 0, '0, 0, 0, 48'd10);
      issue(CMD_CANCEL, 5, '0, 0, 0, 48'd10);
      issue(CMD_NEXT, 0, '0, 0, 0, 48'd10);               // empty table
      clock_ms = 48'd20;

      // Random part in four register settings, one of them with a stretch without idling.
      for (int ph = 0; ph < 4; ph++) begin
         settle();
         write_window(windows[ph]);
         for (int n = 0; n < 78; n++) begin
            calm = (ph == 2 && n < 60);
            if ($urandom_range(99) < 3) burst();
            else random_item();
         end
         calm = 0;
      end

      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### timer_queue_manager_unit.f
+incdir+hdl
hdl/tqm_pkg.sv
hdl/tqm_ctrl.sv
hdl/tqm_datapath.sv
hdl/timer_queue_manager_unit.sv
hdl/tqm_checker.sv
dv/testbench.sv
